// File: src/hslp_pkg.sv
// Shared constants and types for the linear-probe hash set lookup block.
`default_nettype none

package hslp_pkg;

   localparam int TABLE_DEPTH = 65536;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int MAX_LOG2    = $clog2(TABLE_DEPTH + 1) - 1;
   localparam int KEY_W       = 64;
   localparam int SLOT_W      = 16;
   localparam int LOG2_W      = 5;
   localparam int CNT_W       = ADDR_W + 1;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = LOG2_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_TABLE_SIZE_LOG2 = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TABLE_READY     = 1'd1;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef struct packed {
      logic              ready;
      logic [ADDR_W-1:0] mask;
   } cfg_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic found;
   } status_type;

endpackage

`default_nettype wire

// File: src/hslp_engine.sv
// Slot table memory and probe sequencer: load writes and linear probe queries.
`default_nettype none

module hslp_engine (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_go,
   input  wire logic                          req_mode,
   input  wire logic [hslp_pkg::SLOT_W-1:0]   req_slot_index,
   input  wire logic [hslp_pkg::KEY_W-1:0]    req_key_value,
   input  wire hslp_pkg::cfg_type             cfg,
   input  wire logic                          res_take,
   output hslp_pkg::status_type               status
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_FIRST = 2'd1;
   localparam logic [1:0] S_CMP   = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [hslp_pkg::KEY_W-1:0]  mem [hslp_pkg::TABLE_DEPTH];

   logic [1:0]                  state_ff, state_in;
   logic [hslp_pkg::KEY_W-1:0]  key_ff, key_in;
   logic [hslp_pkg::ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic [hslp_pkg::CNT_W-1:0]  cmp_cnt_ff, cmp_cnt_in;
   logic                        found_ff, found_in;
   logic [hslp_pkg::KEY_W-1:0]  rd_data_ff;

   logic [hslp_pkg::KEY_W-1:0]  query_key;
   logic [hslp_pkg::CNT_W-1:0]  size;
   logic [hslp_pkg::CNT_W-1:0]  cmp_cnt_next;
   logic                        wr_en;
   logic [hslp_pkg::ADDR_W-1:0] wr_addr;

   assign query_key    = (req_key_value == '0) ? hslp_pkg::KEY_W'(1) : req_key_value;
   assign size         = {1'b0, cfg.mask} + hslp_pkg::CNT_W'(1);
   assign cmp_cnt_next = cmp_cnt_ff + hslp_pkg::CNT_W'(1);
   assign wr_addr      = hslp_pkg::ADDR_W'(32'(req_slot_index));
   assign wr_en        = (state_ff == S_IDLE) && req_go && (req_mode == hslp_pkg::MODE_LOAD)
                         && (32'(req_slot_index) < 32'(hslp_pkg::TABLE_DEPTH));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_key_value;
      end
      rd_data_ff <= mem[rd_addr_ff];
   end

   always_comb begin
      state_in   = state_ff;
      key_in     = key_ff;
      rd_addr_in = rd_addr_ff;
      cmp_cnt_in = cmp_cnt_ff;
      found_in   = found_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_go && (req_mode == hslp_pkg::MODE_QUERY)) begin
               if (!cfg.ready) begin
                  found_in = 1'b0;
                  state_in = S_DONE;
               end else begin
                  key_in     = query_key;
                  rd_addr_in = query_key[hslp_pkg::ADDR_W-1:0] & cfg.mask;
                  state_in   = S_FIRST;
               end
            end
         end
         S_FIRST: begin
            rd_addr_in = (rd_addr_ff + hslp_pkg::ADDR_W'(1)) & cfg.mask;
            cmp_cnt_in = '0;
            state_in   = S_CMP;
         end
         S_CMP: begin
            rd_addr_in = (rd_addr_ff + hslp_pkg::ADDR_W'(1)) & cfg.mask;
            cmp_cnt_in = cmp_cnt_next;
            if (rd_data_ff == '0) begin
               found_in = 1'b0;
               state_in = S_DONE;
            end else if (rd_data_ff == key_ff) begin
               found_in = 1'b1;
               state_in = S_DONE;
            end else if (cmp_cnt_next == size) begin
               found_in = 1'b0;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      key_ff     <= key_in;
      rd_addr_ff <= rd_addr_in;
      cmp_cnt_ff <= cmp_cnt_in;
      found_ff   <= found_in;
   end

   assign status.busy  = (state_ff != S_IDLE);
   assign status.done  = (state_ff == S_DONE);
   assign status.found = found_ff;

endmodule

`default_nettype wire

// File: src/hash_set_linear_probe_lookup.sv
// Top level of the linear-probe hash set lookup: register port, handshakes, result register.
//
// Membership engine over a table of 64-bit hashes held in a single-port-write,
// registered-read memory of 65536 slots; a zero slot is empty. A load transaction
// (mode 0) writes one slot and returns nothing. A query transaction (mode 1)
// returns one found bit after probing 1 to table-size slots, with the memory read
// port delivering one slot per cycle to the key comparator; the next transaction
// is taken once the query result has entered the result register. A query while
// table_ready is 0 returns a found bit of 0 without probing any slot.
// No new transaction is taken while a query probes or while its result cannot yet
// enter the result register. The slot memory is not cleared by reset: every slot a
// query can reach must be loaded first. Registers: index 0 table_size_log2
// (saturated to 16), index 1 table_ready; write them only while the block is idle.
`default_nettype none

module hash_set_linear_probe_lookup (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output      logic                              req_stall,
   input  wire logic                              req_mode,
   input  wire logic [hslp_pkg::SLOT_W-1:0]       req_slot_index,
   input  wire logic [hslp_pkg::KEY_W-1:0]        req_key_value,
   output      logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   output      logic                              rsp_found,
   input  wire logic                              csr_write_enable,
   input  wire logic [hslp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [hslp_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   logic [hslp_pkg::LOG2_W-1:0] size_log2_ff, size_log2_in;
   logic                        ready_ff, ready_in;
   logic                        rsp_valid_ff;
   logic                        rsp_found_ff;

   logic [hslp_pkg::LOG2_W-1:0] lg_sat;
   hslp_pkg::cfg_type           cfg;
   hslp_pkg::status_type        status;
   logic                        res_take;
   logic                        req_go;

   always_comb begin
      size_log2_in = size_log2_ff;
      ready_in     = ready_ff;
      if (csr_write_enable) begin
         case (csr_index)
            hslp_pkg::CSR_TABLE_SIZE_LOG2: size_log2_in = csr_write_data;
            hslp_pkg::CSR_TABLE_READY:     ready_in     = csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_log2_ff <= '0;
         ready_ff     <= 1'b0;
      end else begin
         size_log2_ff <= size_log2_in;
         ready_ff     <= ready_in;
      end
   end

   assign lg_sat    = (size_log2_ff > hslp_pkg::LOG2_W'(hslp_pkg::MAX_LOG2))
                      ? hslp_pkg::LOG2_W'(hslp_pkg::MAX_LOG2) : size_log2_ff;
   assign cfg.mask  = hslp_pkg::ADDR_W'((32'd1 << lg_sat) - 32'd1);
   assign cfg.ready = ready_ff;

   assign res_take  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = status.busy;
   assign req_go    = req_valid && !req_stall;

   hslp_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .req_go         (req_go),
      .req_mode       (req_mode),
      .req_slot_index (req_slot_index),
      .req_key_value  (req_key_value),
      .cfg            (cfg),
      .res_take       (res_take),
      .status         (status)
   );

   // hold the result until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_take) begin
         rsp_valid_ff <= status.done;
      end
      if (res_take) begin
         rsp_found_ff <= status.found;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;

endmodule

`default_nettype wire

// File: bench/tb_hash_set_linear_probe_lookup.sv
// Testbench for the linear-probe hash set lookup block with its own membership predictor.
`timescale 1ns / 1ps

module tb_hash_set_linear_probe_lookup;

   localparam int CYCLE_LIMIT  = 3000000;
   localparam int HOLD_CYCLES  = 500;
   localparam int WINDOW_SLOTS = 128;

   class found_scoreboard;
      bit [hslp_pkg::KEY_W-1:0]  slots [hslp_pkg::TABLE_DEPTH];
      bit [hslp_pkg::LOG2_W-1:0] size_log2;
      bit                        ready;
      bit                        expected_found [$];
      int                        errors;

      function void write_reg(logic [hslp_pkg::CSR_INDEX_W-1:0] index,
                              logic [hslp_pkg::CSR_DATA_W-1:0] data);
         if (index == hslp_pkg::CSR_TABLE_SIZE_LOG2) begin
            size_log2 = data;
         end else if (index == hslp_pkg::CSR_TABLE_READY) begin
            ready = data[0];
         end
      endfunction

      function bit probe_table(bit [hslp_pkg::KEY_W-1:0] key);
         int unsigned               lg;
         int unsigned               span;
         int unsigned               n;
         bit [hslp_pkg::ADDR_W-1:0] mask;
         bit [hslp_pkg::ADDR_W-1:0] pos;
         bit [hslp_pkg::KEY_W-1:0]  probe_key;
         if (!ready) return 1'b0;
         lg = (size_log2 > hslp_pkg::MAX_LOG2) ? hslp_pkg::MAX_LOG2 : size_log2;
         span = 1 << lg;
         mask = hslp_pkg::ADDR_W'(span - 1);
         probe_key = (key == '0) ? hslp_pkg::KEY_W'(1) : key;
         pos = probe_key[hslp_pkg::ADDR_W-1:0] & mask;
         for (n = 0; n < span; n++) begin
            if (slots[pos] == '0) return 1'b0;
            if (slots[pos] == probe_key) return 1'b1;
            pos = hslp_pkg::ADDR_W'(pos + 1'b1) & mask;
         end
         return 1'b0;
      endfunction

      function void note_transaction(logic mode, logic [hslp_pkg::SLOT_W-1:0] slot,
                                     logic [hslp_pkg::KEY_W-1:0] key);
         if (mode == hslp_pkg::MODE_LOAD) begin
            slots[slot] = key;
         end else begin
            expected_found.push_back(probe_table(key));
         end
      endfunction

      function void check_found(logic found);
         bit want;
         if (expected_found.size() == 0) begin
            $display("%0t: found result with none expected, expected none actual %0b",
                     $time, found);
            errors++;
         end else begin
            want = expected_found.pop_front();
            if (found !== want) begin
               $display("%0t: found mismatch, expected %0b actual %0b", $time, want, found);
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_found.size();
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic                             req_mode;
   logic [hslp_pkg::SLOT_W-1:0]      req_slot_index;
   logic [hslp_pkg::KEY_W-1:0]       req_key_value;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic                             rsp_found;
   logic                             csr_write_enable;
   logic [hslp_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [hslp_pkg::CSR_DATA_W-1:0]  csr_write_data;

   logic                             gaps_on;
   logic                             pressure_req;
   bit                               pressure_done;
   int                               hold_left;
   int                               table_reach;

   found_scoreboard                  sb = new();
   bit [hslp_pkg::KEY_W-1:0]         layout [hslp_pkg::TABLE_DEPTH];
   bit [hslp_pkg::KEY_W-1:0]         stored_keys [$];

   hash_set_linear_probe_lookup u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_slot_index   (req_slot_index),
      .req_key_value    (req_key_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_found        (rsp_found),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.note_transaction(req_mode, req_slot_index, req_key_value);
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_found(rsp_found);
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else if (pressure_req && !pressure_done) begin
         pressure_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= gaps_on && ($urandom_range(99) < 32);
      end
   end

   // keep the probe start inside the loaded window of a large table
   function automatic bit [hslp_pkg::KEY_W-1:0] fit_key(input bit [hslp_pkg::KEY_W-1:0] key,
                                                        input int span, input int reach);
      bit [hslp_pkg::KEY_W-1:0] fitted;
      fitted = key;
      if (reach < span) begin
         fitted[hslp_pkg::ADDR_W-1:0] = hslp_pkg::ADDR_W'($urandom_range(reach - 2));
      end
      return fitted;
   endfunction

   task automatic send_transaction(input logic mode, input logic [hslp_pkg::SLOT_W-1:0] slot,
                                   input logic [hslp_pkg::KEY_W-1:0] key);
      int gap;
      if (gaps_on && $urandom_range(99) < 32) begin
         gap = $urandom_range(1, 4);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_slot_index <= slot;
      req_key_value  <= key;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic write_csr(input logic [hslp_pkg::CSR_INDEX_W-1:0] index,
                            input logic [hslp_pkg::CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      sb.write_reg(index, data);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic build_table(input int span, input int fill_pct);
      int                       count;
      int                       pos;
      int                       i;
      int                       limit;
      bit [hslp_pkg::KEY_W-1:0] key;
      stored_keys.delete();
      table_reach = (span > WINDOW_SLOTS) ? WINDOW_SLOTS : span;
      limit = (table_reach < span) ? table_reach - 1 : table_reach;
      for (i = 0; i < table_reach; i++) layout[i] = '0;
      count = limit * fill_pct / 100;
      for (i = 0; i < count; i++) begin
         key = fit_key({$urandom, $urandom}, span, table_reach);
         if (key == '0 || $urandom_range(19) == 0) key = hslp_pkg::KEY_W'(1);
         pos = int'(key[hslp_pkg::ADDR_W-1:0]) & (span - 1);
         while (layout[pos] != '0) pos = (pos + 1) % limit;
         layout[pos] = key;
         stored_keys.push_back(key);
      end
      for (i = 0; i < table_reach; i++) begin
         send_transaction(hslp_pkg::MODE_LOAD, hslp_pkg::SLOT_W'(i), layout[i]);
      end
   endtask

   task automatic random_traffic(input int span, input int reach, input int count);
      int                        i;
      int                        pick;
      bit [hslp_pkg::KEY_W-1:0]  key;
      bit [hslp_pkg::SLOT_W-1:0] slot;
      for (i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         slot = hslp_pkg::SLOT_W'($urandom_range(16'hFFFF));
         if (pick < 55 && stored_keys.size() != 0) begin
            key = stored_keys[$urandom_range(stored_keys.size() - 1)];
            send_transaction(hslp_pkg::MODE_QUERY, slot, key);
         end else if (pick < 78) begin
            key = fit_key({$urandom, $urandom}, span, reach);
            send_transaction(hslp_pkg::MODE_QUERY, slot, key);
         end else if (pick < 82) begin
            send_transaction(hslp_pkg::MODE_QUERY, slot, hslp_pkg::KEY_W'(0));
         end else if (pick < 95) begin
            case ($urandom_range(2))
               0: key = '0;
               1: begin
                  key = fit_key({$urandom, $urandom}, span, reach);
                  stored_keys.push_back(key);
               end
               default: key = (stored_keys.size() != 0) ?
                              stored_keys[$urandom_range(stored_keys.size() - 1)] :
                              fit_key({$urandom, $urandom}, span, reach);
            endcase
            if (reach < span) begin
               slot = hslp_pkg::SLOT_W'($urandom_range(reach - 2));
            end else begin
               slot = hslp_pkg::SLOT_W'($urandom_range(span - 1));
            end
            send_transaction(hslp_pkg::MODE_LOAD, slot, key);
         end else begin
            if (reach < span) begin
               slot = hslp_pkg::SLOT_W'($urandom_range(16'hFFFF, reach));
            end
            send_transaction(hslp_pkg::MODE_LOAD, slot, {$urandom, $urandom});
         end
      end
   endtask

   task automatic run_phase(input logic [hslp_pkg::LOG2_W-1:0] size_log2, input int fill_pct,
                            input bit refill, input bit ready, input int count);
      int span;
      span = 1 << ((size_log2 > hslp_pkg::MAX_LOG2) ? hslp_pkg::MAX_LOG2 : size_log2);
      drain_block();
      write_csr(hslp_pkg::CSR_TABLE_SIZE_LOG2, size_log2);
      if (refill) begin
         build_table(span, fill_pct);
         drain_block();
      end
      write_csr(hslp_pkg::CSR_TABLE_READY, hslp_pkg::CSR_DATA_W'(ready));
      random_traffic(span, table_reach, count);
   endtask

   initial begin : watchdog
      int unsigned ticks;
      ticks = 0;
      while (ticks < CYCLE_LIMIT) begin
         @(posedge clock);
         ticks++;
      end
      $display("tb_hash_set_linear_probe_lookup NOT OK");
      $finish;
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_mode         = hslp_pkg::MODE_LOAD;
      req_slot_index   = '0;
      req_key_value    = '0;
      csr_write_enable = 1'b0;
      csr_index        = hslp_pkg::CSR_TABLE_SIZE_LOG2;
      csr_write_data   = '0;
      gaps_on          = 1'b1;
      pressure_req     = 1'b0;
      table_reach      = 1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_transaction(hslp_pkg::MODE_QUERY, 16'hFFFF, 64'd0);
      send_transaction(hslp_pkg::MODE_QUERY, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF);
      drain_block();
      write_csr(hslp_pkg::CSR_TABLE_SIZE_LOG2, 5'd2);
      send_transaction(hslp_pkg::MODE_LOAD, 16'd0, 64'h8000_0000_0000_0003);
      send_transaction(hslp_pkg::MODE_LOAD, 16'd1, 64'd1);
      send_transaction(hslp_pkg::MODE_LOAD, 16'd2, 64'd0);
      send_transaction(hslp_pkg::MODE_LOAD, 16'd3, 64'hFFFF_FFFF_FFFF_FFFF);
      drain_block();
      write_csr(hslp_pkg::CSR_TABLE_READY, 5'd1);
      send_transaction(hslp_pkg::MODE_QUERY, 16'h5A5A, 64'd0);
      send_transaction(hslp_pkg::MODE_QUERY, 16'hA5A5, 64'd1);
      send_transaction(hslp_pkg::MODE_QUERY, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF);
      send_transaction(hslp_pkg::MODE_QUERY, 16'hFFFF, 64'h8000_0000_0000_0003);
      send_transaction(hslp_pkg::MODE_QUERY, 16'h0001, 64'd7);
      send_transaction(hslp_pkg::MODE_QUERY, 16'h0002, 64'd2);
      send_transaction(hslp_pkg::MODE_LOAD, 16'd2, 64'h2AAA_AAAA_AAAA_AAA6);
      send_transaction(hslp_pkg::MODE_QUERY, 16'h0003, 64'd4);
      send_transaction(hslp_pkg::MODE_QUERY, 16'h0004, 64'h2AAA_AAAA_AAAA_AAA6);
      drain_block();
      write_csr(hslp_pkg::CSR_TABLE_READY, 5'd0);
      send_transaction(hslp_pkg::MODE_QUERY, 16'h0005, 64'hFFFF_FFFF_FFFF_FFFF);

      run_phase(5'd0, 100, 1'b1, 1'b1, 130);
      run_phase(5'd1, 100, 1'b1, 1'b1, 130);
      pressure_req <= 1'b1;
      run_phase(5'd3, 70, 1'b1, 1'b1, 180);
      gaps_on <= 1'b0;
      run_phase(5'd5, 90, 1'b1, 1'b1, 180);
      gaps_on <= 1'b1;
      run_phase(5'd16, 60, 1'b1, 1'b1, 220);
      run_phase(5'd31, 0, 1'b0, 1'b1, 180);
      run_phase(5'd20, 0, 1'b0, 1'b0, 90);
      run_phase(5'd4, 100, 1'b1, 1'b1, 180);
      run_phase(5'd2, 50, 1'b1, 1'b1, 130);

      drain_block();
      repeat (16) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_hash_set_linear_probe_lookup OK");
      end else begin
         $display("tb_hash_set_linear_probe_lookup NOT OK");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/hslp_pkg.sv
src/hslp_engine.sv
src/hash_set_linear_probe_lookup.sv
bench/tb_hash_set_linear_probe_lookup.sv
